### rtl/psrm_pkg.sv
// ----------------------------------------------------------------------------
// psrm_pkg
// Shared widths, character codes, operation codes and the command/status
// bundles between the controller and the datapath of the square residue mask.
// ----------------------------------------------------------------------------
package psrm_pkg;

    localparam int PRIME_W    = 9;
    localparam int OPND_W     = 2 * PRIME_W;      // a*b + c with a, b, c below 512
    localparam int TABLE_SIZE = 512;
    localparam int TAB_AW     = $clog2(TABLE_SIZE);
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int MOD_STEPS  = OPND_W;
    localparam int STEP_W     = $clog2(MOD_STEPS + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [3:0]        RADIX    = 4'd10;

    typedef logic [PRIME_W-1:0] t_res;

    // operand selection for the shared multiply-add and reduction
    typedef logic [1:0] t_op;
    localparam t_op OP_DIGIT  = 2'd0;   // 10*residue + digit
    localparam t_op OP_REDUCE = 2'd1;   // residue
    localparam t_op OP_SQUARE = 2'd2;   // x*x
    localparam t_op OP_HORNER = 2'd3;   // v*x + coeff

    typedef struct packed {
        logic load_item;
        logic char_step;
        logic mod_start;
        t_op  op;
        logic take_digit;
        logic store_coeff;
        logic x_clear;
        logic x_inc;
        logic tbl_clear;
        logic tbl_fill;
        logic run_setup;
        logic horner_init;
        logic i_dec;
        logic v_take;
        logic tbl_read;
        logic bit_take;
        logic emit;
        logic run_end;
    } t_cmd;

    typedef struct packed {
        logic char_digit;
        logic str_end;
        logic poly_end;
        logic mod_done;
        logic i_zero;
        logic x_last;
        logic word_end;
    } t_sts;

    // a prime below 2 behaves as 2; a 9-bit prime always fits the table
    function automatic t_res active_prime(input t_res prime);
        return (prime < t_res'(2)) ? t_res'(2) : prime;
    endfunction

endpackage

### rtl/psrm_modred.sv
// ----------------------------------------------------------------------------
// psrm_modred
// Bit-serial modular reduction: one operand bit per cycle, MSB first,
// restoring remainder kept below the prime.
// ----------------------------------------------------------------------------
module psrm_modred import psrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OPND_W-1:0] i_operand,
    input  t_res              i_prime,
    output logic              o_done,
    output t_res              o_res
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [OPND_W-1:0] r_sh;
    t_res              r_rem;
    logic [PRIME_W:0]  trial;
    t_res              n_rem;

    always_comb begin
        trial = {r_rem, r_sh[OPND_W-1]};
        if (trial >= {1'b0, i_prime}) begin
            n_rem = PRIME_W'(trial - {1'b0, i_prime});
        end else begin
            n_rem = trial[PRIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MOD_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_operand;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[OPND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("reduction started while busy");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("reduction done without a finished run");

endmodule

### rtl/psrm_datapath.sv
// ----------------------------------------------------------------------------
// psrm_datapath
// Item capture, string residue, coefficient store, squares table memory,
// Horner evaluation registers and mask word assembly.
// ----------------------------------------------------------------------------
module psrm_datapath import psrm_pkg::*; #(
    parameter int MAX_COEFFS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_res                 i_prime,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_char_valid,
    input  logic                 i_end_of_coeff,
    input  logic                 i_end_of_poly,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_strobe,
    output logic [WORD_BITS-1:0] o_mask_word,
    output logic [WIDX_W-1:0]    o_word_index,
    output logic                 o_last_word,
    output logic                 o_input_error
);

    localparam int CCW = $clog2(MAX_COEFFS + 1);
    localparam int CIW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    // captured item
    logic [CHAR_W-1:0]    r_ch;
    logic                 r_cvalid;
    logic                 r_eoc;
    logic                 r_eop;
    // string and run state
    t_res                 r_digit;
    logic                 r_neg;
    logic                 r_at_start;
    logic                 r_err;
    logic [CCW-1:0]       r_count;
    t_res                 r_coeff [MAX_COEFFS];
    // evaluation
    t_res                 r_x;
    t_res                 r_v;
    logic [CCW-1:0]       r_i;
    logic [BIT_W-1:0]     r_j;
    logic [WIDX_W-1:0]    r_w;
    logic [WORD_BITS-1:0] r_mask;
    logic                 r_tbl [TABLE_SIZE];
    logic                 r_tbl_q;

    logic                 is_sign;
    logic                 is_digit;
    logic                 x_last;
    logic [CCW-1:0]       i_m1;
    t_res                 op_a;
    t_res                 op_b;
    t_res                 op_c;
    logic [OPND_W-1:0]    operand;
    logic                 mod_done;
    t_res                 mod_res;
    t_res                 signed_res;
    logic                 tbl_we;
    logic [TAB_AW-1:0]    tbl_wa;
    logic [WORD_BITS-1:0] n_mask;

    assign is_sign  = (r_ch == CH_MINUS) || (r_ch == CH_PLUS);
    assign is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign x_last   = (r_x == i_prime - 1'b1);
    assign i_m1     = r_i - 1'b1;

    always_comb begin
        unique case (i_cmd.op)
            OP_DIGIT: begin
                op_a = r_digit;
                op_b = PRIME_W'(RADIX);
                op_c = PRIME_W'(r_ch - CH_ZERO);
            end
            OP_REDUCE: begin
                op_a = r_digit;
                op_b = PRIME_W'(1);
                op_c = '0;
            end
            OP_SQUARE: begin
                op_a = r_x;
                op_b = r_x;
                op_c = '0;
            end
            OP_HORNER: begin
                op_a = r_v;
                op_b = r_x;
                op_c = r_coeff[i_m1[CIW-1:0]];
            end
            default: begin
                op_a = '0;
                op_b = '0;
                op_c = '0;
            end
        endcase
    end

    assign operand = OPND_W'(op_a) * OPND_W'(op_b) + OPND_W'(op_c);

    psrm_modred u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mod_start),
        .i_operand (operand),
        .i_prime   (i_prime),
        .o_done    (mod_done),
        .o_res     (mod_res)
    );

    assign signed_res = (r_neg && (mod_res != '0)) ? i_prime - mod_res : mod_res;
    assign n_mask     = r_mask | (WORD_BITS'(r_tbl_q) << r_j);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit    <= '0;
            r_neg      <= 1'b0;
            r_at_start <= 1'b1;
            r_err      <= 1'b0;
            r_count    <= '0;
            r_mask     <= '0;
            o_strobe   <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
            if (i_cmd.char_step && r_cvalid) begin
                if (r_at_start && is_sign) begin
                    r_neg <= (r_ch == CH_MINUS);
                end else if (!is_digit) begin
                    r_err <= 1'b1;
                end
                r_at_start <= 1'b0;
            end
            if (i_cmd.take_digit) begin
                r_digit <= mod_res;
            end
            if (i_cmd.store_coeff) begin
                if (r_count < CCW'(MAX_COEFFS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_err <= 1'b1;
                end
                r_digit    <= '0;
                r_neg      <= 1'b0;
                r_at_start <= 1'b1;
            end
            if (i_cmd.run_setup) begin
                r_mask <= '0;
            end
            if (i_cmd.bit_take) begin
                r_mask <= i_cmd.emit ? '0 : n_mask;
            end
            if (i_cmd.run_end) begin
                r_count    <= '0;
                r_err      <= 1'b0;
                r_digit    <= '0;
                r_neg      <= 1'b0;
                r_at_start <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ch     <= i_char_code;
            r_cvalid <= i_char_valid;
            r_eoc    <= i_end_of_coeff;
            r_eop    <= i_end_of_poly;
        end
        if (i_cmd.store_coeff && (r_count < CCW'(MAX_COEFFS))) begin
            r_coeff[r_count[CIW-1:0]] <= signed_res;
        end
        if (i_cmd.x_clear) begin
            r_x <= '0;
        end else if (i_cmd.x_inc) begin
            r_x <= r_x + 1'b1;
        end
        if (i_cmd.horner_init) begin
            r_v <= '0;
            r_i <= r_count;
        end else begin
            if (i_cmd.i_dec) begin
                r_i <= i_m1;
            end
            if (i_cmd.v_take) begin
                r_v <= mod_res;
            end
        end
        if (i_cmd.run_setup) begin
            r_j <= '0;
            r_w <= '0;
        end else if (i_cmd.bit_take) begin
            if (i_cmd.emit) begin
                r_j <= '0;
                r_w <= r_w + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            o_mask_word   <= n_mask;
            o_word_index  <= r_w;
            o_last_word   <= x_last;
            o_input_error <= r_err;
        end
    end

    // squares table: one write port, one registered read port
    assign tbl_we = i_cmd.tbl_clear || i_cmd.tbl_fill;
    assign tbl_wa = i_cmd.tbl_clear ? TAB_AW'(r_x) : TAB_AW'(mod_res);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_wa] <= i_cmd.tbl_fill;
        end
        if (i_cmd.tbl_read) begin
            r_tbl_q <= r_tbl[TAB_AW'(r_v)];
        end
    end

    always_comb begin
        o_sts.char_digit = r_cvalid && is_digit;
        o_sts.str_end    = r_eoc || r_eop;
        o_sts.poly_end   = r_eop;
        o_sts.mod_done   = mod_done;
        o_sts.i_zero     = (r_i == '0);
        o_sts.x_last     = x_last;
        o_sts.word_end   = (r_j == BIT_W'(WORD_BITS - 1)) || x_last;
    end

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("mask words on adjacent cycles");

    a_last_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_word) |-> ((r_count == '0) && !r_err && r_at_start))
        else $error("run state not cleared with the last word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CCW'(MAX_COEFFS))
        else $error("coefficient count past the store depth");

endmodule

### rtl/psrm_ctrl.sv
// ----------------------------------------------------------------------------
// psrm_ctrl
// Sequencer: character step, string reduction, table clear and fill,
// Horner evaluation per x and mask word emission.
// ----------------------------------------------------------------------------
module psrm_ctrl import psrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAR  = 4'd1;
    localparam logic [3:0] S_DWAIT = 4'd2;
    localparam logic [3:0] S_EOS   = 4'd3;
    localparam logic [3:0] S_RWAIT = 4'd4;
    localparam logic [3:0] S_CLR   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_SWAIT = 4'd7;
    localparam logic [3:0] S_HINIT = 4'd8;
    localparam logic [3:0] S_HTEST = 4'd9;
    localparam logic [3:0] S_HWAIT = 4'd10;
    localparam logic [3:0] S_HBIT  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_CHAR;
                end
            end
            S_CHAR: begin
                o_cmd.char_step = 1'b1;
                if (i_sts.char_digit) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.op        = OP_DIGIT;
                    n_state         = S_DWAIT;
                end else begin
                    n_state = S_EOS;
                end
            end
            S_DWAIT: begin
                if (i_sts.mod_done) begin
                    o_cmd.take_digit = 1'b1;
                    n_state          = S_EOS;
                end
            end
            S_EOS: begin
                if (i_sts.str_end) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.op        = OP_REDUCE;
                    n_state         = S_RWAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RWAIT: begin
                o_cmd.op = OP_REDUCE;
                if (i_sts.mod_done) begin
                    o_cmd.store_coeff = 1'b1;
                    if (i_sts.poly_end) begin
                        o_cmd.x_clear = 1'b1;
                        n_state       = S_CLR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLR: begin
                o_cmd.tbl_clear = 1'b1;
                if (i_sts.x_last) begin
                    o_cmd.x_clear = 1'b1;
                    n_state       = S_SQ;
                end else begin
                    o_cmd.x_inc = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.op        = OP_SQUARE;
                n_state         = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.mod_done) begin
                    o_cmd.tbl_fill = 1'b1;
                    if (i_sts.x_last) begin
                        o_cmd.x_clear   = 1'b1;
                        o_cmd.run_setup = 1'b1;
                        n_state         = S_HINIT;
                    end else begin
                        o_cmd.x_inc = 1'b1;
                        n_state     = S_SQ;
                    end
                end
            end
            S_HINIT: begin
                o_cmd.horner_init = 1'b1;
                n_state           = S_HTEST;
            end
            S_HTEST: begin
                o_cmd.op = OP_HORNER;
                if (i_sts.i_zero) begin
                    o_cmd.tbl_read = 1'b1;
                    n_state        = S_HBIT;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.i_dec     = 1'b1;
                    n_state         = S_HWAIT;
                end
            end
            S_HWAIT: begin
                if (i_sts.mod_done) begin
                    o_cmd.v_take = 1'b1;
                    n_state      = S_HTEST;
                end
            end
            S_HBIT: begin
                o_cmd.bit_take = 1'b1;
                o_cmd.emit     = i_sts.word_end;
                if (i_sts.x_last) begin
                    o_cmd.run_end = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.x_inc = 1'b1;
                    n_state     = S_HINIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/polynomial_square_residue_mask_top.sv
// ----------------------------------------------------------------------------
// polynomial_square_residue_mask_top
// Quadratic residue mask of a polynomial given as decimal coefficient strings.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one character beat is taken at a clock edge with start high and
//   busy low. Strings arrive lowest power first; end_of_coeff closes a
//   string, end_of_poly closes the last one and starts the mask run.
//   Config: i_cfg_we writes the prime (values below 2 act as 2); write only
//   while busy is low.
//   Output: each mask word is shown for one cycle with o_strobe high; the
//   receiver cannot stall, so it must take every word as it comes.
// Sequence (p = prime):
//   a digit keeps busy high longer than any other character, and a beat
//   that closes a string holds busy for one more reduction. The final item
//   then clears p table entries, fills them and evaluates every x before
//   the last word. The bit-serial reduction unit, shared by every modular
//   step, sets the pace.
// Reset: synchronous, active low; returns the prime to 2 and the string and
//   run state to empty. The squares table is cleared at the start of each run.
// ----------------------------------------------------------------------------
module polynomial_square_residue_mask_top import psrm_pkg::*; #(
    parameter int MAX_COEFFS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [PRIME_W-1:0]   i_cfg_wdata,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_char_valid,
    input  logic                 i_end_of_coeff,
    input  logic                 i_end_of_poly,
    output logic                 o_strobe,
    output logic [WORD_BITS-1:0] o_mask_word,
    output logic [WIDX_W-1:0]    o_word_index,
    output logic                 o_last_word,
    output logic                 o_input_error
);

    t_res r_prime;
    t_res prime_act;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= t_res'(2);
        end else if (i_cfg_we) begin
            r_prime <= i_cfg_wdata;
        end
    end

    assign prime_act = active_prime(r_prime);

    psrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    psrm_datapath #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_prime        (prime_act),
        .i_char_code    (i_char_code),
        .i_char_valid   (i_char_valid),
        .i_end_of_coeff (i_end_of_coeff),
        .i_end_of_poly  (i_end_of_poly),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_mask_word    (o_mask_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_input_error  (o_input_error)
    );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams decimal coefficient strings into the square residue mask block,
// works out every mask word from its own copy of the block's state and
// checks each word against it as it arrives, over a series of primes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psrm_pkg::*;

    localparam int COEFF_SLOTS   = 16;
    localparam int IDLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_BEATS   = 8;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              valid;
        logic              eoc;
        logic              eop;
    } t_char_beat;

    typedef struct {
        logic [WORD_BITS-1:0] bits;
        logic [WIDX_W-1:0]    index;
        logic                 is_last;
        logic                 err;
    } t_mask_word;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic                 i_cfg_we       = 1'b0;
    logic [PRIME_W-1:0]   i_cfg_wdata    = '0;
    logic [CHAR_W-1:0]    i_char_code    = '0;
    logic                 i_char_valid   = 1'b0;
    logic                 i_end_of_coeff = 1'b0;
    logic                 i_end_of_poly  = 1'b0;
    logic                 o_strobe;
    logic [WORD_BITS-1:0] o_mask_word;
    logic [WIDX_W-1:0]    o_word_index;
    logic                 o_last_word;
    logic                 o_input_error;

    t_char_beat  char_beats[$];
    t_mask_word  mask_words_due[$];
    int unsigned mismatches   = 0;
    int unsigned beats_queued = 0;
    int unsigned idle_cycles  = 0;
    bit          beat_taken   = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;

    // predicted block state
    t_res       model_prime    = t_res'(2);
    t_res       model_coeffs [COEFF_SLOTS];
    logic [4:0] model_count    = '0;
    t_res       model_residue  = '0;
    logic       model_negative = 1'b0;
    logic       model_at_start = 1'b1;
    logic       model_error    = 1'b0;

    polynomial_square_residue_mask_top #(
        .MAX_COEFFS (COEFF_SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_char_code    (i_char_code),
        .i_char_valid   (i_char_valid),
        .i_end_of_coeff (i_end_of_coeff),
        .i_end_of_poly  (i_end_of_poly),
        .o_strobe       (o_strobe),
        .o_mask_word    (o_mask_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_input_error  (o_input_error)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Fold one character beat into the state; on end of polynomial queue the mask.
    task automatic predict_mask_words(input t_char_beat b);
        int unsigned p, v, acc, x, w, j, k, n_words;
        bit          squares [TABLE_SIZE];
        t_mask_word  mw;
        p = (model_prime < t_res'(2)) ? 2 : model_prime;
        if (p > TABLE_SIZE) p = TABLE_SIZE;
        if (b.valid) begin
            if (model_at_start && (b.code == CH_MINUS || b.code == CH_PLUS)) begin
                model_negative = (b.code == CH_MINUS);
            end else if (b.code >= CH_ZERO && b.code <= CH_NINE) begin
                model_residue = t_res'((10 * (model_residue % p) + (b.code - CH_ZERO)) % p);
            end else begin
                model_error = 1'b1;
            end
            model_at_start = 1'b0;
        end
        if (!(b.eoc || b.eop)) return;

        v = model_residue % p;
        if (model_negative && v != 0) v = p - v;
        if (model_count < COEFF_SLOTS) begin
            model_coeffs[model_count] = t_res'(v);
            model_count++;
        end else begin
            model_error = 1'b1;
        end
        model_residue  = '0;
        model_negative = 1'b0;
        model_at_start = 1'b1;
        if (!b.eop) return;

        foreach (squares[i]) squares[i] = 1'b0;
        for (x = 0; x < p; x++) squares[(x * x) % p] = 1'b1;

        n_words = (p + WORD_BITS - 1) / WORD_BITS;
        for (w = 0; w < n_words; w++) begin
            mw.bits = '0;
            for (j = 0; j < WORD_BITS; j++) begin
                x = w * WORD_BITS + j;
                if (x < p) begin
                    acc = 0;
                    for (k = model_count; k > 0; k--)
                        acc = (acc * x + model_coeffs[k - 1]) % p;
                    if (squares[acc]) mw.bits[j] = 1'b1;
                end
            end
            mw.index   = w[WIDX_W-1:0];
            mw.is_last = (w + 1 == n_words);
            mw.err     = model_error;
            mask_words_due = {mask_words_due, mw};
        end
        model_count = '0;
        model_error = 1'b0;
    endtask

    // Take beats and register writes as the block sees them.
    always @(posedge i_clk) begin
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) model_prime = i_cfg_wdata;
            if (start && !busy) begin
                predict_mask_words(char_beats.pop_front());
                beat_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_mask_word want;
        if (i_rst_n && o_strobe) begin
            if (mask_words_due.size() == 0) begin
                report_mismatch("unexpected word", o_mask_word, '0);
            end else begin
                want = mask_words_due.pop_front();
                if (o_mask_word !== want.bits)
                    report_mismatch("mask_word", o_mask_word, want.bits);
                if (o_word_index !== want.index)
                    report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                if (o_last_word !== want.is_last)
                    report_mismatch("last_word", 32'(o_last_word), 32'(want.is_last));
                if (o_input_error !== want.err)
                    report_mismatch("input_error", 32'(o_input_error), 32'(want.err));
            end
        end
    end

    // Bursts of beats with random gaps; hold a beat until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !beat_taken)) begin
            if (beat_taken) begin
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (char_beats.size() > 0) begin
                start          <= 1'b1;
                i_char_code    <= char_beats[0].code;
                i_char_valid   <= char_beats[0].valid;
                i_end_of_coeff <= char_beats[0].eoc;
                i_end_of_poly  <= char_beats[0].eop;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_beat(input logic [CHAR_W-1:0] code, input logic valid,
                             input logic eoc, input logic eop);
        t_char_beat b;
        b.code  = code;
        b.valid = valid;
        b.eoc   = eoc;
        b.eop   = eop;
        char_beats = {char_beats, b};
        if (valid || eoc || eop) beats_queued++;
    endtask

    task automatic push_text(input string text, input logic eoc, input logic eop);
        int k;
        if (text.len() == 0) push_beat(8'h00, 1'b0, eoc, eop);
        for (k = 0; k < text.len(); k++)
            push_beat(text[k], 1'b1, eoc && k == text.len() - 1, eop && k == text.len() - 1);
    endtask

    task automatic push_random_coeff(input int max_digits, input logic eoc, input logic eop);
        int                n_chars, k, roll;
        bit                signed_str;
        logic [CHAR_W-1:0] c;
        signed_str = ($urandom_range(0, 2) != 0);
        n_chars    = $urandom_range(0, max_digits) + (signed_str ? 1 : 0);
        if (n_chars == 0) push_beat(CHAR_W'($urandom_range(0, 255)), 1'b0, eoc, eop);
        for (k = 0; k < n_chars; k++) begin
            roll = $urandom_range(0, 99);
            if (k == 0 && signed_str)
                c = ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS;
            else if (roll < 6)
                c = CHAR_W'($urandom_range(0, 255));
            else if (roll < 9)
                c = ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS;
            else
                c = CH_ZERO + CHAR_W'($urandom_range(0, 9));
            push_beat(c, 1'b1, eoc && k == n_chars - 1, eop && k == n_chars - 1);
        end
    endtask

    // Large primes get few coefficients to keep the mask run short.
    task automatic push_random_poly(input int unsigned p, input bit closed, input bit many);
        int   n_coeffs, max_digits, k;
        logic tail_eoc;
        if (p > 128) begin
            n_coeffs   = $urandom_range(1, 3);
            max_digits = 6;
        end else if (many) begin
            n_coeffs   = $urandom_range(17, 19);
            max_digits = 1;
        end else begin
            n_coeffs   = $urandom_range(1, 6);
            max_digits = 4;
        end
        for (k = 0; k < n_coeffs; k++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            if (closed && k == n_coeffs - 1) begin
                tail_eoc = ($urandom_range(0, 3) != 0);
                push_random_coeff(max_digits, tail_eoc, 1'b1);
            end else begin
                push_random_coeff(max_digits, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic wait_idle();
        while (char_beats.size() != 0 || start || busy || mask_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_prime(input int unsigned value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[PRIME_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned phase_primes[$];
        int unsigned phase_start;
        bit          first;
        phase_primes = '{0, 1, 3, 511, 31, 32, 33, 97, 256, 13, 509, 5, 127, 64};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // signs, empty strings, bad characters, extreme codes, long digit run
        write_prime(7);
        push_text("-12", 1'b1, 1'b0);
        push_text("+3", 1'b1, 1'b0);
        push_text("", 1'b1, 1'b0);
        push_text("-", 1'b1, 1'b0);
        push_text("9a5", 1'b1, 1'b0);
        push_text("4-", 1'b1, 1'b0);
        push_text("+", 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        push_beat(8'h5A, 1'b0, 1'b0, 1'b0);
        push_text("99999999", 1'b0, 1'b1);

        foreach (phase_primes[n]) begin
            write_prime(phase_primes[n]);
            phase_start = beats_queued;
            first       = 1'b1;
            while (beats_queued - phase_start < PHASE_BEATS) begin
                push_random_poly(phase_primes[n], 1'b1,
                                 phase_primes[n] <= 16 && (first || $urandom_range(0, 2) == 0));
                first = 1'b0;
            end
            // leave a polynomial open across the next prime change
            if (phase_primes[n] == 33) push_random_poly(phase_primes[n], 1'b0, 1'b0);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/psrm_pkg.sv
rtl/psrm_modred.sv
rtl/psrm_datapath.sv
rtl/psrm_ctrl.sv
rtl/polynomial_square_residue_mask_top.sv
sim/testbench.sv
